// ===== rtl/core/ebrc_pkg.sv =====
package ebrc_pkg;

  // fixed field widths
  localparam int TS_W        = 40;
  localparam int ANGLE_W     = 12;
  localparam int STATE_W     = 2;
  localparam int COUNT_OUT_W = 7;
  localparam int WINDOW_W    = 20;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  // defaults for the top level parameters
  localparam int DEF_FIFO_DEPTH = 64;
  localparam int DEF_TIME_WIDTH = 40;

  // eye state codes
  localparam logic [STATE_W-1:0] EYE_OPEN   = 2'd1;
  localparam logic [STATE_W-1:0] EYE_CLOSED = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_HI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_LO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_HI     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW     = 3'd4;

  // register reset values
  localparam logic signed [ANGLE_W-1:0] RST_PITCH_HI = 12'sd1800;
  localparam logic signed [ANGLE_W-1:0] RST_YAW_LO   = -12'sd1800;
  localparam logic signed [ANGLE_W-1:0] RST_YAW_HI   = 12'sd1800;
  localparam logic [WINDOW_W-1:0]       RST_WINDOW   = 20'd60000;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic eval;
    logic rd_req;
    logic pop;
    logic load_out;
  } ebrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic blink;
    logic more;
    logic stale;
  } ebrc_sts_t;

endpackage

// ===== rtl/core/ebrc_if.sv =====
interface ebrc_frame_if import ebrc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATE_W-1:0]        eye_code;
  logic signed [ANGLE_W-1:0] head_pitch;
  logic signed [ANGLE_W-1:0] head_yaw;
  logic [TS_W-1:0]           frame_time_ms;

  modport source (output valid, eye_code, head_pitch, head_yaw, frame_time_ms,
                  input ready);
  modport sink (input valid, eye_code, head_pitch, head_yaw, frame_time_ms,
                output ready);
endinterface

interface ebrc_result_if import ebrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   blink_seen;
  logic [TS_W-1:0]        closing_start_ms;
  logic [TS_W-1:0]        closing_end_ms;
  logic [TS_W-1:0]        blink_length_ms;
  logic [COUNT_OUT_W-1:0] blinks_in_window;
  logic                   frame_skipped;

  modport source (output valid, blink_seen, closing_start_ms, closing_end_ms,
                  blink_length_ms, blinks_in_window, frame_skipped,
                  input ready);
  modport sink (input valid, blink_seen, closing_start_ms, closing_end_ms,
                blink_length_ms, blinks_in_window, frame_skipped,
                output ready);
endinterface

interface ebrc_cfg_if import ebrc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/core/ebrc_ctrl.sv =====
module ebrc_ctrl import ebrc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ebrc_sts_t sts,
  output ebrc_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state == ST_IDLE) && in_valid;
    cmd.eval     = (state == ST_EVAL);
    cmd.rd_req   = (state == ST_READ) && sts.more;
    cmd.pop      = (state == ST_CHECK) && sts.stale;
    cmd.load_out = (state == ST_EMIT) && (!out_valid || out_ready);
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EVAL;
      ST_EVAL:  state_next = sts.blink ? ST_READ : ST_EMIT;
      ST_READ:  state_next = sts.more ? ST_CHECK : ST_EMIT;
      ST_CHECK: state_next = sts.stale ? ST_READ : ST_EMIT;
      ST_EMIT:  if (cmd.load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/ebrc_dp.sv =====
module ebrc_dp import ebrc_pkg::*; #(
  parameter int BLINK_FIFO_DEPTH = DEF_FIFO_DEPTH,
  parameter int TIME_WIDTH       = DEF_TIME_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ebrc_cmd_t                 cmd,
  output ebrc_sts_t                 sts,
  input  logic [STATE_W-1:0]        eye_code,
  input  logic signed [ANGLE_W-1:0] head_pitch,
  input  logic signed [ANGLE_W-1:0] head_yaw,
  input  logic [TS_W-1:0]           frame_time_ms,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  output logic                      blink_seen,
  output logic [TS_W-1:0]           closing_start_ms,
  output logic [TS_W-1:0]           closing_end_ms,
  output logic [TS_W-1:0]           blink_length_ms,
  output logic [COUNT_OUT_W-1:0]    blinks_in_window,
  output logic                      frame_skipped
);

  localparam int AW = $clog2(BLINK_FIFO_DEPTH);
  localparam int CW = $clog2(BLINK_FIFO_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(BLINK_FIFO_DEPTH);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(BLINK_FIFO_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(BLINK_FIFO_DEPTH - 1);

  // configuration
  logic                      gate_en;
  logic signed [ANGLE_W-1:0] pitch_hi;
  logic signed [ANGLE_W-1:0] yaw_lo;
  logic signed [ANGLE_W-1:0] yaw_hi;
  logic [WINDOW_W-1:0]       window;

  // frame held while it is worked on
  logic [STATE_W-1:0]        st_q;
  logic signed [ANGLE_W-1:0] pitch_q;
  logic signed [ANGLE_W-1:0] yaw_q;
  logic [TIME_WIDTH-1:0]     now_q;

  // detector and fifo state
  logic                  open_armed;
  logic                  closure_seen;
  logic [TIME_WIDTH-1:0] last_open_time;
  logic [AW-1:0]         fifo_head;
  logic [CW-1:0]         fifo_count;
  logic [TIME_WIDTH-1:0] fifo_mem [BLINK_FIFO_DEPTH];
  logic [TIME_WIDTH-1:0] rd_data;

  // result of the frame, before the output stage
  logic                  res_blink;
  logic                  res_skip;
  logic [TIME_WIDTH-1:0] res_start;
  logic [TIME_WIDTH-1:0] res_end;
  logic [TIME_WIDTH-1:0] res_len;

  logic                  angle_out;
  logic                  skip;
  logic                  blink;
  logic                  full;
  logic                  mem_we;
  logic [AW:0]           wr_sum;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         head_inc;
  logic [TIME_WIDTH-1:0] age;

  assign angle_out = gate_en && (pitch_q > pitch_hi || yaw_q > yaw_hi || yaw_q < yaw_lo);
  assign skip      = !(st_q == EYE_OPEN || st_q == EYE_CLOSED) || angle_out;
  assign blink     = !skip && (st_q == EYE_OPEN) && open_armed && closure_seen;
  assign full      = (fifo_count == DEPTH_C);
  assign mem_we    = cmd.eval && blink;

  // tail slot, wrapped once
  assign wr_sum  = {1'b0, fifo_head} + (AW + 1)'(fifo_count);
  always_comb begin
    if (wr_sum >= DEPTH_X) begin
      wr_addr = AW'(wr_sum - DEPTH_X);
    end else begin
      wr_addr = wr_sum[AW-1:0];
    end
  end

  assign head_inc = (fifo_head == LAST_IDX) ? '0 : fifo_head + 1'b1;
  assign age      = now_q - rd_data;

  assign sts.blink = blink;
  assign sts.more  = (fifo_count > CW'(1));
  assign sts.stale = (age > TIME_WIDTH'(window));

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_en  <= 1'b0;
      pitch_hi <= RST_PITCH_HI;
      yaw_lo   <= RST_YAW_LO;
      yaw_hi   <= RST_YAW_HI;
      window   <= RST_WINDOW;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_GATE: gate_en  <= cfg_wdata[0];
        REG_PITCH_HI:   pitch_hi <= signed'(cfg_wdata[ANGLE_W-1:0]);
        REG_YAW_LO:     yaw_lo   <= signed'(cfg_wdata[ANGLE_W-1:0]);
        REG_YAW_HI:     yaw_hi   <= signed'(cfg_wdata[ANGLE_W-1:0]);
        REG_WINDOW:     window   <= cfg_wdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      st_q    <= eye_code;
      pitch_q <= head_pitch;
      yaw_q   <= head_yaw;
      now_q   <= TIME_WIDTH'(frame_time_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_armed     <= 1'b0;
      closure_seen   <= 1'b0;
      last_open_time <= '0;
      fifo_head      <= '0;
      fifo_count     <= '0;
    end else if (cmd.eval) begin
      if (!skip) begin
        if (st_q == EYE_CLOSED) begin
          closure_seen <= 1'b1;
        end else begin
          open_armed     <= 1'b1;
          closure_seen   <= 1'b0;
          last_open_time <= now_q;
          if (blink) begin
            // full: oldest slot is overwritten and head moves on
            if (full) begin
              fifo_head <= head_inc;
            end else begin
              fifo_count <= fifo_count + 1'b1;
            end
          end
        end
      end
    end else if (cmd.pop) begin
      fifo_head  <= head_inc;
      fifo_count <= fifo_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_skip  <= skip;
      res_blink <= blink;
      res_start <= blink ? last_open_time : '0;
      res_end   <= blink ? now_q : '0;
      res_len   <= blink ? now_q - last_open_time : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fifo_mem[wr_addr] <= now_q;
    end
    if (cmd.rd_req) begin
      rd_data <= fifo_mem[fifo_head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      blink_seen       <= res_blink;
      frame_skipped    <= res_skip;
      closing_start_ms <= TS_W'(res_start);
      closing_end_ms   <= TS_W'(res_end);
      blink_length_ms  <= TS_W'(res_len);
      blinks_in_window <= COUNT_OUT_W'(fifo_count);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= DEPTH_C)
    else $error("fifo count above depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    int'(fifo_head) < BLINK_FIFO_DEPTH)
    else $error("fifo head out of range");

  a_pop_keeps_newest: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> fifo_count > CW'(1))
    else $error("pop would drop the newest blink");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> fifo_count != '0)
    else $error("fifo empty after a push");

endmodule

// ===== rtl/core/eye_blink_rate_counter_core.sv =====
// flow: an accepted frame is held and evaluated; after a blink the fifo head is read and its
//   age compared, stale entries are popped until one is left or the head is in the window
// throughput: a new frame is accepted only in the idle state, once the word of the last one is
//   loaded; the read-compare-pop loop over the blink time memory and output back pressure slow it
// reset: rst is synchronous; it clears the detector, the fifo pointers and the output
//   valid and loads the register defaults; the blink time memory itself is not cleared
module eye_blink_rate_counter_core import ebrc_pkg::*; #(
  parameter int BLINK_FIFO_DEPTH = DEF_FIFO_DEPTH,
  parameter int TIME_WIDTH       = DEF_TIME_WIDTH
) (
  input logic             clk,
  input logic             rst,
  ebrc_frame_if.sink      frame_in,
  ebrc_result_if.source   result_out,
  ebrc_cfg_if.sink        cfg
);

  // command and status between sequencer and datapath
  ebrc_cmd_t cmd;
  ebrc_sts_t sts;

  // register writes always taken; user must write only while block is idle, not enforced
  assign cfg.ready = 1'b1;

  // sequencer: idle -> evaluate -> (read head, check age)* -> emit word
  ebrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frame_in.valid),
    .in_ready  (frame_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: registers, blink detector, blink time fifo and output stage
  ebrc_dp #(
    .BLINK_FIFO_DEPTH (BLINK_FIFO_DEPTH),
    .TIME_WIDTH       (TIME_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .eye_code         (frame_in.eye_code),
    .head_pitch       (frame_in.head_pitch),
    .head_yaw         (frame_in.head_yaw),
    .frame_time_ms    (frame_in.frame_time_ms),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.reg_index),
    .cfg_wdata        (cfg.wdata),
    .blink_seen       (result_out.blink_seen),
    .closing_start_ms (result_out.closing_start_ms),
    .closing_end_ms   (result_out.closing_end_ms),
    .blink_length_ms  (result_out.blink_length_ms),
    .blinks_in_window (result_out.blinks_in_window),
    .frame_skipped    (result_out.frame_skipped)
  );

endmodule

// ===== dv/eye_blink_rate_counter_core_tb.sv =====
`timescale 1ns / 100ps

module eye_blink_rate_counter_core_tb;
  import ebrc_pkg::*;

  // eye state codes that the package leaves out
  localparam logic [STATE_W-1:0] EYE_UNKNOWN = 2'd0;
  localparam logic [STATE_W-1:0] EYE_CODE3   = 2'd3;

  localparam int FIFO_DEPTH = DEF_FIFO_DEPTH;
  localparam int HEAD_W     = $clog2(FIFO_DEPTH);

  localparam logic [TS_W-1:0]           TS_MAX     = '1;
  localparam logic [WINDOW_W-1:0]       WINDOW_MAX = '1;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN  = 12'sh800;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = 12'sh7FF;

  // percent of cycles in which a side holds off
  localparam int IDLE_PCT    = 36;
  // cycles with no word moving on any channel before the run is called dead
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic                   blink_seen;
    logic [TS_W-1:0]        closing_start_ms;
    logic [TS_W-1:0]        closing_end_ms;
    logic [TS_W-1:0]        blink_length_ms;
    logic [COUNT_OUT_W-1:0] blinks_in_window;
    logic                   frame_skipped;
  } blink_report_t;

  logic clk;
  logic rst;

  ebrc_frame_if  frame_if ();
  ebrc_result_if result_if ();
  ebrc_cfg_if    cfg_if ();

  eye_blink_rate_counter_core #(
    .BLINK_FIFO_DEPTH(FIFO_DEPTH),
    .TIME_WIDTH(TS_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .frame_in(frame_if),
    .result_out(result_if),
    .cfg(cfg_if)
  );

  // register copies as the block should hold them
  logic                      gate_en;
  logic signed [ANGLE_W-1:0] pitch_hi;
  logic signed [ANGLE_W-1:0] yaw_lo;
  logic signed [ANGLE_W-1:0] yaw_hi;
  logic [WINDOW_W-1:0]       window_ms;

  // blink detector and blink time fifo as the block should hold them
  logic                   armed;
  logic                   closure_seen;
  logic [TS_W-1:0]        last_open_ms;
  logic [TS_W-1:0]        blink_times [FIFO_DEPTH];
  logic [HEAD_W-1:0]      fifo_head;
  logic [COUNT_OUT_W-1:0] fifo_count;

  // one expected result word per accepted frame, oldest first
  blink_report_t expected_reports[$];
  int            mismatch_count = 0;

  // both sides hold off at random while this is set
  bit traffic_gaps = 1'b1;

  // running frame clock and last generated eye state of the random streams
  logic [TS_W-1:0]    now_ms = '0;
  logic [STATE_W-1:0] prev_state = EYE_OPEN;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void reset_tracker();
    gate_en      = 1'b0;
    pitch_hi     = RST_PITCH_HI;
    yaw_lo       = RST_YAW_LO;
    yaw_hi       = RST_YAW_HI;
    window_ms    = RST_WINDOW;
    armed        = 1'b0;
    closure_seen = 1'b0;
    last_open_ms = '0;
    fifo_head    = '0;
    fifo_count   = '0;
  endfunction

  // advances the detector by one frame and returns the word it should report
  function automatic blink_report_t advance_blink_tracker(
    input logic [STATE_W-1:0]        eye,
    input logic signed [ANGLE_W-1:0] pitch,
    input logic signed [ANGLE_W-1:0] yaw,
    input logic [TS_W-1:0]           stamp
  );
    blink_report_t     rep;
    logic [TS_W-1:0]   age;
    logic [HEAD_W-1:0] slot;
    logic              pruning;
    rep = '0;
    // unknown and state three are never evaluated
    rep.frame_skipped = !(eye == EYE_OPEN || eye == EYE_CLOSED);
    // pitch has an upper limit only, yaw has both
    if (gate_en && (pitch > pitch_hi || yaw > yaw_hi || yaw < yaw_lo))
      rep.frame_skipped = 1'b1;
    if (!rep.frame_skipped) begin
      if (eye == EYE_CLOSED) begin
        // closure counts even before the first open frame
        closure_seen = 1'b1;
      end else begin
        if (armed && closure_seen) begin
          rep.blink_seen       = 1'b1;
          rep.closing_start_ms = last_open_ms;
          rep.closing_end_ms   = stamp;
          rep.blink_length_ms  = stamp - last_open_ms;
          // a full fifo gives up its oldest entry first
          if (fifo_count >= FIFO_DEPTH) begin
            fifo_head++;
            fifo_count--;
          end
          slot = fifo_head + HEAD_W'(fifo_count);
          blink_times[slot] = stamp;
          fifo_count++;
          // drop entries older than the window, never the newest one;
          // ages wrap, so a backward timestamp drops everything older
          pruning = 1'b1;
          while (pruning && fifo_count > 1) begin
            age = stamp - blink_times[fifo_head];
            if (age > TS_W'(window_ms)) begin
              fifo_head++;
              fifo_count--;
            end else begin
              pruning = 1'b0;
            end
          end
        end
        // every open frame rearms the sequence
        armed        = 1'b1;
        last_open_ms = stamp;
        closure_seen = 1'b0;
      end
    end
    rep.blinks_in_window = fifo_count;
    return rep;
  endfunction

  function automatic void check_field(input string label, input logic [TS_W-1:0] want,
                                      input logic [TS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [TS_W-1:0] rand_stamp();
    return TS_W'({$urandom, $urandom});
  endfunction

  // angle registers ignore the upper bits of the write word, so fill them at random
  function automatic logic [CFG_DATA_W-1:0] angle_word(input logic signed [ANGLE_W-1:0] angle);
    return {(CFG_DATA_W-ANGLE_W)'($urandom), angle};
  endfunction

  // one frame word; valid stays up after acceptance so back to back words need no gap
  task automatic send_frame(
    input logic [STATE_W-1:0]        eye,
    input logic signed [ANGLE_W-1:0] pitch,
    input logic signed [ANGLE_W-1:0] yaw,
    input logic [TS_W-1:0]           stamp
  );
    while (traffic_gaps && $urandom_range(99) < IDLE_PCT) begin
      frame_if.valid <= 1'b0;
      @(posedge clk);
    end
    frame_if.valid         <= 1'b1;
    frame_if.eye_code      <= eye;
    frame_if.head_pitch    <= pitch;
    frame_if.head_yaw      <= yaw;
    frame_if.frame_time_ms <= stamp;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
    expected_reports.insert(expected_reports.size(),
                            advance_blink_tracker(eye, pitch, yaw, stamp));
  endtask

  // hold off the sender until every outstanding word is back, then settle
  task automatic drain_results(input int settle);
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_ANGLE_GATE: gate_en = value[0];
      REG_PITCH_HI:   pitch_hi = value[ANGLE_W-1:0];
      REG_YAW_LO:     yaw_lo = value[ANGLE_W-1:0];
      REG_YAW_HI:     yaw_hi = value[ANGLE_W-1:0];
      REG_WINDOW:     window_ms = value[WINDOW_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // registers change only with the block idle
  task automatic apply_settings(
    input logic                      gate,
    input logic signed [ANGLE_W-1:0] p_hi,
    input logic signed [ANGLE_W-1:0] y_lo,
    input logic signed [ANGLE_W-1:0] y_hi,
    input logic [WINDOW_W-1:0]       win
  );
    drain_results(8);
    write_register(REG_ANGLE_GATE, {(CFG_DATA_W-1)'($urandom), gate});
    write_register(REG_PITCH_HI, angle_word(p_hi));
    write_register(REG_YAW_LO, angle_word(y_lo));
    write_register(REG_YAW_HI, angle_word(y_hi));
    write_register(REG_WINDOW, CFG_DATA_W'(win));
  endtask

  // mostly open/closed/open sequences with random timing, some noise states,
  // some angles outside the limits and, when asked, timestamp jumps both ways
  task automatic run_frame_stream(input int frames, input int max_step, input bit jumps);
    logic [STATE_W-1:0]        eye;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] yaw;
    int                        lo;
    int                        hi;
    int                        pick;
    repeat (frames) begin
      pick = $urandom_range(99);
      if (pick < 10)
        eye = STATE_W'($urandom);
      else if (prev_state == EYE_CLOSED)
        eye = (pick < 70) ? EYE_OPEN : EYE_CLOSED;
      else
        eye = (pick < 80) ? EYE_CLOSED : EYE_OPEN;
      prev_state = eye;

      if ($urandom_range(99) < 12) begin
        pitch = ANGLE_W'($urandom);
        yaw   = ANGLE_W'($urandom);
      end else begin
        hi    = pitch_hi;
        pitch = ANGLE_W'($urandom_range(hi + 2048) - 2048);
        lo    = yaw_lo;
        hi    = yaw_hi;
        yaw   = (lo <= hi) ? ANGLE_W'($urandom_range(hi - lo) + lo) : ANGLE_W'($urandom);
      end

      pick = $urandom_range(99);
      if (jumps && pick < 3)
        now_ms = now_ms - TS_W'($urandom_range(4 * max_step + 1));
      else if (jumps && pick < 5)
        now_ms = rand_stamp();
      else
        now_ms = now_ms + TS_W'($urandom_range(max_step));
      send_frame(eye, pitch, yaw, now_ms);
    end
  endtask

  // random register set; extremes and an all-gated setting come up regularly
  task automatic randomize_settings(output int max_step);
    logic signed [ANGLE_W-1:0] p;
    logic signed [ANGLE_W-1:0] a;
    logic signed [ANGLE_W-1:0] b;
    logic signed [ANGLE_W-1:0] t;
    logic [WINDOW_W-1:0]       w;
    int                        pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      p = ANGLE_MAX;
      a = ANGLE_MIN;
      b = ANGLE_MAX;
    end else if (pick < 30) begin
      // crossed limits: every frame with the gate on is skipped
      p = ANGLE_MIN;
      a = ANGLE_MAX;
      b = ANGLE_MIN;
    end else begin
      p = ANGLE_W'($urandom);
      a = ANGLE_W'($urandom);
      b = ANGLE_W'($urandom);
      if (a > b && $urandom_range(99) < 85) begin
        t = a;
        a = b;
        b = t;
      end
    end
    pick = $urandom_range(99);
    if (pick < 25)
      w = WINDOW_W'($urandom_range(200));
    else if (pick < 50)
      w = WINDOW_W'($urandom_range(5000));
    else if (pick < 75)
      w = WINDOW_W'($urandom_range(600000));
    else
      w = WINDOW_W'($urandom);
    // timing step scaled to the window so the fifo fills to varying depths
    max_step = (w >> 4) + 2;
    apply_settings(1'($urandom_range(1)), p, a, b, w);
  endtask

  // reset register values, the arming rules and skipped states
  task automatic test_blink_basics();
    send_frame(EYE_CLOSED, 0, 0, 40'd5);             // closure before anything is armed
    send_frame(EYE_OPEN, 0, 0, 40'd10);              // first open only arms
    send_frame(EYE_OPEN, 0, 0, 40'd20);              // open again, no closure yet
    send_frame(EYE_CLOSED, ANGLE_MAX, ANGLE_MIN, 40'd30);
    send_frame(EYE_UNKNOWN, 0, 0, 40'd35);
    send_frame(EYE_CODE3, 0, 0, 40'd38);
    send_frame(EYE_OPEN, 0, 0, 40'd50);              // completes a blink
    send_frame(EYE_CLOSED, ANGLE_MIN, ANGLE_MAX, 40'd60);
    send_frame(EYE_CLOSED, 0, 0, 40'd70);
    send_frame(EYE_OPEN, 0, 0, 40'd90);              // blink over two closed frames
  endtask

  // limits are inclusive, pitch has no lower bound, a gated closure is lost
  task automatic test_angle_gate();
    apply_settings(1'b1, 100, -200, 200, RST_WINDOW);
    send_frame(EYE_OPEN, 100, 200, 40'd100);
    send_frame(EYE_CLOSED, 101, 0, 40'd110);
    send_frame(EYE_OPEN, 0, -200, 40'd120);
    send_frame(EYE_CLOSED, 0, 201, 40'd130);
    send_frame(EYE_CLOSED, 0, -201, 40'd135);
    send_frame(EYE_CLOSED, ANGLE_MIN, -200, 40'd140);
    send_frame(EYE_OPEN, 0, 0, 40'd150);
  endtask

  // top of the timestamp range, wrap past zero and a backward step
  task automatic test_time_wrap();
    apply_settings(1'b0, RST_PITCH_HI, RST_YAW_LO, RST_YAW_HI, 20'd1000);
    send_frame(EYE_CLOSED, 0, 0, TS_MAX - 40'd10);
    send_frame(EYE_OPEN, 0, 0, TS_MAX);
    send_frame(EYE_CLOSED, 0, 0, TS_MAX);
    send_frame(EYE_OPEN, 0, 0, 40'd3);
    send_frame(EYE_CLOSED, 0, 0, 40'd500);
    send_frame(EYE_OPEN, 0, 0, 40'd400);
    now_ms = 40'd400;
  endtask

  // widest window and tight frame timing fill the fifo past its depth;
  // its frame stream runs with both sides at full rate
  task automatic test_window_saturation();
    apply_settings(1'b0, ANGLE_MAX, ANGLE_MIN, ANGLE_MAX, WINDOW_MAX);
    traffic_gaps = 1'b0;
    run_frame_stream(220, 20, 1'b0);
    traffic_gaps = 1'b1;
  endtask

  // zero window keeps only blinks that share the newest timestamp
  task automatic test_zero_window();
    apply_settings(1'b1, 12'sd1800, -12'sd1800, 12'sd1800, '0);
    run_frame_stream(150, 3, 1'b1);
  endtask

  task automatic test_random_traffic();
    int step;
    repeat (4) begin
      randomize_settings(step);
      run_frame_stream(60, step, 1'b1);
      // sender waits for every outstanding word before going on
      drain_results(0);
      run_frame_stream(65, step, 1'b1);
    end
  endtask

  // result side: random back pressure, every accepted word against the oldest expectation
  initial begin
    blink_report_t want;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result word with no frame outstanding", $time);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("blink_seen", TS_W'(want.blink_seen), TS_W'(result_if.blink_seen));
          check_field("closing_start_ms", want.closing_start_ms, result_if.closing_start_ms);
          check_field("closing_end_ms", want.closing_end_ms, result_if.closing_end_ms);
          check_field("blink_length_ms", want.blink_length_ms, result_if.blink_length_ms);
          check_field("blinks_in_window", TS_W'(want.blinks_in_window),
                      TS_W'(result_if.blinks_in_window));
          check_field("frame_skipped", TS_W'(want.frame_skipped),
                      TS_W'(result_if.frame_skipped));
        end
      end
      result_if.ready <= !(traffic_gaps && $urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog: ends a run in which no word moves on any channel for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst                    <= 1'b1;
    frame_if.valid         <= 1'b0;
    frame_if.eye_code      <= EYE_UNKNOWN;
    frame_if.head_pitch    <= '0;
    frame_if.head_yaw      <= '0;
    frame_if.frame_time_ms <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.reg_index       <= REG_ANGLE_GATE;
    cfg_if.wdata           <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    reset_tracker();

    test_blink_basics();
    test_angle_gate();
    test_time_wrap();
    test_window_saturation();
    test_zero_window();
    test_random_traffic();

    // a blink may walk the whole fifo, so leave room for stray late words
    drain_results(2 * FIFO_DEPTH + 8);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
